[src/m4m_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the 4x4 fixed-point matrix multiplier.
package m4m_pkg;

    localparam int MAT_DIM   = 4;
    localparam int MAT_SIZE  = MAT_DIM * MAT_DIM;
    localparam int DIM_W     = $clog2(MAT_DIM);
    localparam int INDEX_W   = $clog2(MAT_SIZE);
    localparam int DATA_W    = 32;
    localparam int OPCODE_W  = 2;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + DIM_W;

    localparam logic [OPCODE_W-1:0] OP_WRITE_LEFT  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE_RIGHT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PRODUCT     = 2'd2;

    typedef struct packed {
        logic mul_en;
        logic first;
    } mac_ctrl_t;

endpackage

[src/m4m_store.sv]
`timescale 1ns / 1ps
// Sixteen-entry matrix store, cleared to zero on reset.
module m4m_store
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [m4m_pkg::INDEX_W-1:0]         wr_addr,
    input  logic signed [m4m_pkg::DATA_W-1:0]   wr_data,
    input  logic [m4m_pkg::INDEX_W-1:0]         rd_addr,
    output logic signed [m4m_pkg::DATA_W-1:0]   rd_data
);

    logic signed [m4m_pkg::DATA_W-1:0] mem_reg [m4m_pkg::MAT_SIZE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < m4m_pkg::MAT_SIZE; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_addr];

endmodule

[src/m4m_mac.sv]
`timescale 1ns / 1ps
// Shared multiply-accumulate unit with Q16.16 shift and saturation.
module m4m_mac
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  m4m_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [m4m_pkg::DATA_W-1:0]   a,
    input  logic signed [m4m_pkg::DATA_W-1:0]   b,
    output logic signed [m4m_pkg::DATA_W-1:0]   sat_value
);

    localparam int HIGH_W = m4m_pkg::ACC_W - m4m_pkg::FRAC_BITS;

    logic signed [m4m_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_vld_reg;
    logic                              first_reg;
    logic signed [m4m_pkg::ACC_W-1:0]  acc_reg;
    logic signed [m4m_pkg::ACC_W-1:0]  acc_base;
    logic signed [HIGH_W-1:0]          shifted;
    logic                              fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
            first_reg    <= ctrl.first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= a * b;
        end
        if (prod_vld_reg)
        begin
            acc_reg <= acc_base + m4m_pkg::ACC_W'(prod_reg);
        end
    end

    // Restart the sum on the first product of an element
    assign acc_base = first_reg ? '0 : acc_reg;

    // Arithmetic shift of the exact sum is the floor of sum / 2^16
    assign shifted = acc_reg[m4m_pkg::ACC_W-1:m4m_pkg::FRAC_BITS];
    assign fits    = (shifted[HIGH_W-1:m4m_pkg::DATA_W-1] == '0) ||
                     (shifted[HIGH_W-1:m4m_pkg::DATA_W-1] == '1);

    always_comb
    begin
        if (fits)
        begin
            sat_value = shifted[m4m_pkg::DATA_W-1:0];
        end
        else if (shifted[HIGH_W-1])
        begin
            sat_value = {1'b1, {(m4m_pkg::DATA_W-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(m4m_pkg::DATA_W-1){1'b1}}};
        end
    end

endmodule

[src/matrix4_multiply.sv]
`timescale 1ns / 1ps
// Top level: 4x4 Q16.16 matrix multiplier with element load and product readout.
// Element writes leave the input ready, so a new request can follow each one.
// A product request streams 16 words in element-index order; the input stays busy
// until the last word is loaded into the output register.
// Per element: four multiplier passes, four accumulates and one output load.
// Output backpressure stalls the run; reset clears both stores and the output.
module matrix4_multiply
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [m4m_pkg::OPCODE_W-1:0]        opcode,
    input  logic [m4m_pkg::INDEX_W-1:0]         element_index,
    input  logic signed [m4m_pkg::DATA_W-1:0]   element_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [m4m_pkg::INDEX_W-1:0]         result_index,
    output logic signed [m4m_pkg::DATA_W-1:0]   result_value,
    output logic                                last_element
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    localparam logic [m4m_pkg::INDEX_W-1:0] LAST_IDX = m4m_pkg::INDEX_W'(m4m_pkg::MAT_SIZE - 1);
    localparam logic [m4m_pkg::DIM_W-1:0]   LAST_K   = m4m_pkg::DIM_W'(m4m_pkg::MAT_DIM - 1);

    state_t                              state_reg, state_next;
    logic [m4m_pkg::INDEX_W-1:0]         elem_reg, elem_next;
    logic [m4m_pkg::DIM_W-1:0]           k_reg, k_next;
    logic                                out_valid_reg, out_valid_next;
    logic [m4m_pkg::INDEX_W-1:0]         out_index_reg, out_index_next;
    logic signed [m4m_pkg::DATA_W-1:0]   out_value_reg, out_value_next;
    logic                                out_last_reg, out_last_next;

    logic                                accept;
    logic                                wr_left;
    logic                                wr_right;
    logic [m4m_pkg::DIM_W-1:0]           row;
    logic [m4m_pkg::DIM_W-1:0]           col;
    logic [m4m_pkg::INDEX_W-1:0]         left_addr;
    logic [m4m_pkg::INDEX_W-1:0]         right_addr;
    logic signed [m4m_pkg::DATA_W-1:0]   left_data;
    logic signed [m4m_pkg::DATA_W-1:0]   right_data;
    logic signed [m4m_pkg::DATA_W-1:0]   sat_value;
    m4m_pkg::mac_ctrl_t                  mac_ctrl;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign wr_left  = accept && (opcode == m4m_pkg::OP_WRITE_LEFT);
    assign wr_right = accept && (opcode == m4m_pkg::OP_WRITE_RIGHT);

    // Column-major: left(row,k) at row + 4k, right(k,col) at k + 4col
    assign row        = elem_reg[m4m_pkg::DIM_W-1:0];
    assign col        = elem_reg[m4m_pkg::INDEX_W-1:m4m_pkg::DIM_W];
    assign left_addr  = {k_reg, row};
    assign right_addr = {col, k_reg};

    assign mac_ctrl.mul_en = (state_reg == ST_MUL);
    assign mac_ctrl.first  = (state_reg == ST_MUL) && (k_reg == '0);

    m4m_store u_left
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_left),
        .wr_addr (element_index),
        .wr_data (element_value),
        .rd_addr (left_addr),
        .rd_data (left_data)
    );

    m4m_store u_right
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_right),
        .wr_addr (element_index),
        .wr_data (element_value),
        .rd_addr (right_addr),
        .rd_data (right_data)
    );

    m4m_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .a         (left_data),
        .b         (right_data),
        .sat_value (sat_value)
    );

    always_comb
    begin
        state_next     = state_reg;
        elem_next      = elem_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == m4m_pkg::OP_PRODUCT))
                begin
                    elem_next  = '0;
                    k_next     = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == LAST_K)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold the finished sum until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = elem_reg;
                    out_value_next = sat_value;
                    out_last_next  = (elem_reg == LAST_IDX);
                    k_next         = '0;
                    elem_next      = elem_reg + 1'b1;
                    state_next     = (elem_reg == LAST_IDX) ? ST_IDLE : ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            elem_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elem_reg      <= elem_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_value_reg <= out_value_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_index = out_index_reg;
    assign result_value = out_value_reg;
    assign last_element = out_last_reg;

endmodule
